FILE: rtl/multichannel_adc_window_averager_assert.svh
// ----------------------------------------------------------------------------
// Multichannel ADC window averager assertion macros
// Concurrent assertion wrappers clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef MULTICHANNEL_ADC_WINDOW_AVERAGER_ASSERT_SVH
`define MULTICHANNEL_ADC_WINDOW_AVERAGER_ASSERT_SVH
`ifndef ASSERT_OFF
`define MCAW_ASSERT(lbl, prop, msg) lbl: assert property (@(posedge clk) \
	disable iff (!arst_n) prop) else $error(msg);
`define MCAW_NEVER(lbl, expr, msg) lbl: assert property (@(posedge clk) \
	disable iff (!arst_n) !(expr)) else $error(msg);
`else
`define MCAW_ASSERT(lbl, prop, msg)
`define MCAW_NEVER(lbl, expr, msg)
`endif
`endif

FILE: rtl/mcaw_pkg.sv
// ----------------------------------------------------------------------------
// Multichannel ADC window averager package
// Field widths, default sizes and the analogue input select codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mcaw_pkg;

	localparam int SAMPLE_W         = 10;
	localparam int CHANNEL_W        = 2;
	localparam int SELECT_W         = 3;
	localparam int CH_CODE_W        = 3;
	localparam int DEF_CHANNELS     = 3;
	localparam int DEF_WINDOW_DEPTH = 32;

	localparam logic [SELECT_W-1:0] SEL_CH0  = 3'h6;
	localparam logic [SELECT_W-1:0] SEL_CH1  = 3'h4;
	localparam logic [SELECT_W-1:0] SEL_CH2  = 3'h2;
	localparam logic [SELECT_W-1:0] SEL_NONE = 3'h0;

	function automatic logic [SELECT_W-1:0] select_code(input logic [CH_CODE_W-1:0] ch);
		logic [SELECT_W-1:0] code;
		case (ch)
			3'd0: code = SEL_CH0;
			3'd1: code = SEL_CH1;
			3'd2: code = SEL_CH2;
			default: code = SEL_NONE;
		endcase
		return code;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/multichannel_adc_window_averager.sv
// ----------------------------------------------------------------------------
// Multichannel ADC window averager
// Throughput: one item per cycle unless result_ready holds the output back;
// the window memory is read on acceptance and written when the item leaves
// stage one, always at a different entry.
// Reset clears counters, sums, held averages and valid flags at once; the
// window memory needs no clearing pass as first-pass reads are discarded.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "multichannel_adc_window_averager_assert.svh"

module multichannel_adc_window_averager #(
	parameter int CHANNELS     = mcaw_pkg::DEF_CHANNELS,
	parameter int WINDOW_DEPTH = mcaw_pkg::DEF_WINDOW_DEPTH
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          sample_valid,
	output logic                               sample_ready,
	input  wire logic [mcaw_pkg::SAMPLE_W-1:0] sample,
	output logic                               result_valid,
	input  wire logic                          result_ready,
	output logic [mcaw_pkg::CHANNEL_W-1:0]     channel,
	output logic [mcaw_pkg::SAMPLE_W-1:0]      average,
	output logic                               refreshed,
	output logic                               window_ready,
	output logic [mcaw_pkg::SELECT_W-1:0]      next_select
);

	import mcaw_pkg::*;

	localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int SLOT_W   = $clog2(WINDOW_DEPTH);
	localparam int ENTRIES  = CHANNELS * WINDOW_DEPTH;
	localparam int ADDR_W   = $clog2(ENTRIES);
	localparam int SUM_W    = SAMPLE_W + $clog2(WINDOW_DEPTH);
	localparam int RECIP_SH = SUM_W + $clog2(WINDOW_DEPTH);
	localparam int PROD_W   = 2 * SUM_W + 2;
	localparam longint unsigned RECIP_M =
		((longint'(1) << RECIP_SH) + longint'(WINDOW_DEPTH) - 1) / longint'(WINDOW_DEPTH);

	logic [SAMPLE_W-1:0] window_mem [ENTRIES];

	logic [CH_W-1:0]     ch_q;
	logic [SLOT_W-1:0]   slot_q;
	logic                filled_q;
	logic [ADDR_W-1:0]   addr_q;

	logic [SUM_W-1:0]    sums_q [CHANNELS];
	logic [SAMPLE_W-1:0] held_q [CHANNELS];

	logic                valid_s1;
	logic [SAMPLE_W-1:0] sample_s1;
	logic [SAMPLE_W-1:0] rdata_s1;
	logic [CH_W-1:0]     ch_s1;
	logic [SLOT_W-1:0]   slot_s1;
	logic                filled_s1;
	logic                filled_nx_s1;
	logic [ADDR_W-1:0]   addr_s1;
	logic [SELECT_W-1:0] select_s1;

	logic                result_valid_q;
	logic [CHANNEL_W-1:0] channel_q;
	logic [SAMPLE_W-1:0] average_q;
	logic                refreshed_q;
	logic                window_ready_q;
	logic [SELECT_W-1:0] next_select_q;

	logic                accept;
	logic                move;
	logic                last_ch;
	logic                last_slot;
	logic [CH_W-1:0]     ch_nx;
	logic [SLOT_W-1:0]   slot_nx;
	logic                filled_nx;
	logic [ADDR_W-1:0]   addr_nx;

	logic [SAMPLE_W-1:0] old_sample;
	logic [SUM_W-1:0]    new_sum;
	logic [PROD_W-1:0]   product;
	logic                on_grid;
	logic [SAMPLE_W-1:0] new_avg;
	logic                new_refresh;

	assign move         = valid_s1 && (!result_valid_q || result_ready);
	assign sample_ready = !valid_s1 || move;
	assign accept       = sample_valid && sample_ready;

	assign last_ch   = (ch_q == CH_W'(CHANNELS - 1));
	assign last_slot = (slot_q == SLOT_W'(WINDOW_DEPTH - 1));
	assign ch_nx     = last_ch ? '0 : ch_q + 1'b1;
	assign slot_nx   = !last_ch ? slot_q : (last_slot ? '0 : slot_q + 1'b1);
	assign filled_nx = filled_q || (last_ch && last_slot);
	assign addr_nx   = (addr_q == ADDR_W'(ENTRIES - 1)) ? '0 : addr_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ch_q     <= '0;
			slot_q   <= '0;
			filled_q <= 1'b0;
			addr_q   <= '0;
		end else if (accept) begin
			ch_q     <= ch_nx;
			slot_q   <= slot_nx;
			filled_q <= filled_nx;
			addr_q   <= addr_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			window_mem[addr_s1] <= sample_s1;
		end
		if (accept) begin
			rdata_s1 <= window_mem[addr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample_ready) begin
			valid_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1    <= sample;
			ch_s1        <= ch_q;
			slot_s1      <= slot_q;
			filled_s1    <= filled_q;
			filled_nx_s1 <= filled_nx;
			addr_s1      <= addr_q;
			select_s1    <= select_code(CH_CODE_W'(ch_nx));
		end
	end

	// Entries are first written during the fill pass, so until then the memory
	// read is ignored and zero is taken as the overwritten value.
	assign old_sample  = filled_s1 ? rdata_s1 : '0;
	assign new_sum     = sums_q[ch_s1] - SUM_W'(old_sample) + SUM_W'(sample_s1);
	assign product     = PROD_W'(new_sum) * PROD_W'(RECIP_M);
	assign on_grid     = ((slot_s1 & SLOT_W'(3)) == '0);
	assign new_refresh = !filled_s1 || on_grid;

	always_comb begin
		if (!filled_s1) begin
			new_avg = sample_s1;
		end else if (on_grid) begin
			new_avg = product[RECIP_SH +: SAMPLE_W];
		end else begin
			new_avg = held_q[ch_s1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				sums_q[i] <= '0;
				held_q[i] <= '0;
			end
		end else if (move) begin
			sums_q[ch_s1] <= new_sum;
			held_q[ch_s1] <= new_avg;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (move) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			channel_q      <= CHANNEL_W'(ch_s1);
			average_q      <= new_avg;
			refreshed_q    <= new_refresh;
			window_ready_q <= filled_nx_s1;
			next_select_q  <= select_s1;
		end
	end

	assign result_valid = result_valid_q;
	assign channel      = channel_q;
	assign average      = average_q;
	assign refreshed    = refreshed_q;
	assign window_ready = window_ready_q;
	assign next_select  = next_select_q;

	`MCAW_NEVER(a_no_rw_clash, accept && move && (addr_q == addr_s1), "read and write hit one entry")
	`MCAW_ASSERT(a_fill_refresh, move && !filled_s1 |=> refreshed_q, "fill-phase item not refreshed")
	`MCAW_ASSERT(a_accept_loads, accept |=> valid_s1, "accepted item lost before stage one")
	`MCAW_ASSERT(a_ch_range, 1'b1 |-> (ch_q <= CH_W'(CHANNELS - 1)), "channel counter out of range")

endmodule

`default_nettype wire
